@@ rtl/arsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arsp_pkg;

  localparam int unsigned N_STAGES      = 19;
  localparam int unsigned ST_DIV_FIRST  = 1;
  localparam int unsigned ST_DIV_LAST   = 8;
  localparam int unsigned ST_QUANT      = 9;
  localparam int unsigned ST_SRCH_FIRST = 10;
  localparam int unsigned ST_SRCH_LAST  = 17;
  localparam int unsigned ST_PACK       = 18;

  localparam logic [16:0] Q_ONE      = 17'h10000;
  localparam logic [16:0] LIN_LIMIT  = 17'd205;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_LINEAR_OUTPUT = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] accum_red;
    logic [31:0] accum_green;
    logic [31:0] accum_blue;
    logic [31:0] accum_weight;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [31:0] packed_pixel;
    logic [23:0] dest_index;
  } out_word_t;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][15:0] quo;
    logic [2:0]       sat;
    logic [2:0][16:0] q;
    logic [2:0][7:0]  lin;
    logic [2:0][7:0]  k;
    logic             wzero;
    logic [31:0]      weight;
    logic [11:0]      x;
    logic [23:0]      row;
    logic [23:0]      idx;
    logic [31:0]      pix;
  } pipe_t;

  typedef logic [16:0] thr_tab_t [256];
  typedef logic [7:0]  lin_tab_t [256];

  // smallest q with q^5 * 10761^12 >= (40k+541)^12 * 2^80
  function automatic logic [16:0] srgb_thr(int unsigned k);
    logic [255:0] c;
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    c = 256'd1;
    rhs = 256'd1;
    lo = 0;
    hi = 65536;
    for (int i = 0; i < 12; i++) begin
      c = c * 256'd10761;
      rhs = rhs * 256'(40 * k + 541);
    end
    rhs = rhs << 80;
    for (int it = 0; it < 18; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        lhs = 256'd1;
        for (int j = 0; j < 5; j++) lhs = lhs * 256'(mid);
        lhs = lhs * c;
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
    end
    return 17'(lo);
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    t[0] = '0;
    for (int k = 1; k < 256; k++) t[k] = srgb_thr(k);
    return t;
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int j = 0; j < 256; j++) t[j] = 8'((j * 32946 + 327680) / 655360);
    return t;
  endfunction

  localparam thr_tab_t SRGB_THR = build_thr();
  localparam lin_tab_t LIN_TAB  = build_lin();

  function automatic pipe_t pipe_load(in_word_t w, logic [12:0] height);
    pipe_t r;
    r = '0;
    r.rem[0] = w.accum_red;
    r.rem[1] = w.accum_green;
    r.rem[2] = w.accum_blue;
    r.sat[0] = w.accum_red >= w.accum_weight;
    r.sat[1] = w.accum_green >= w.accum_weight;
    r.sat[2] = w.accum_blue >= w.accum_weight;
    r.wzero  = (w.accum_weight == '0);
    r.weight = w.accum_weight;
    r.x      = w.pixel_x;
    r.row    = {11'd0, height} - 24'd1 - {12'd0, w.pixel_y};
    return r;
  endfunction

  function automatic pipe_t pipe_step(int unsigned st, pipe_t p, logic lin_mode,
                                      logic [12:0] width);
    pipe_t r;
    logic [32:0] sh;
    logic [24:0] lm;
    logic [7:0]  cand;
    logic [7:0]  ch;
    int unsigned b;
    r = p;
    if (st >= ST_DIV_FIRST && st <= ST_DIV_LAST) begin
      // two restoring divide steps per stage
      for (int c = 0; c < 3; c++) begin
        for (int s = 0; s < 2; s++) begin
          sh = {r.rem[c], 1'b0};
          if (sh >= {1'b0, r.weight}) begin
            sh = sh - {1'b0, r.weight};
            r.quo[c] = {r.quo[c][14:0], 1'b1};
          end else begin
            r.quo[c] = {r.quo[c][14:0], 1'b0};
          end
          r.rem[c] = sh[31:0];
        end
      end
    end
    if (st == 1) r.idx = 24'(r.row * width);
    if (st == 2) r.idx = r.idx + {12'd0, r.x};
    if (st == ST_QUANT) begin
      for (int c = 0; c < 3; c++) begin
        r.q[c] = r.sat[c] ? Q_ONE : {1'b0, r.quo[c]};
        lm = 25'(r.q[c]) * 25'd255 + 25'd32768;
        r.lin[c] = lin_mode ? lm[23:16] : LIN_TAB[r.q[c][7:0]];
        r.k[c] = '0;
      end
    end
    if (st >= ST_SRCH_FIRST && st <= ST_SRCH_LAST) begin
      b = ST_SRCH_LAST - st;
      for (int c = 0; c < 3; c++) begin
        cand = r.k[c] | 8'(1 << b);
        if (r.q[c] >= SRGB_THR[cand]) r.k[c] = cand;
      end
    end
    if (st == ST_PACK) begin
      r.pix[31:24] = 8'hFF;
      for (int c = 0; c < 3; c++) begin
        if (r.wzero) ch = '0;
        else if (lin_mode || r.q[c] <= LIN_LIMIT) ch = r.lin[c];
        else ch = r.k[c];
        r.pix[8*c +: 8] = ch;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/accum_resolve_srgb_pack_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Resolves accumulated pixels to RGBA8888: each channel sum / weight, clamped
// to 1.0, then linear or sRGB encoded to 8 bits, alpha 255, with a y-flipped
// destination index. One word per clock in and out. The pipeline holds the
// 16-bit pipelined divider (2 quotient bits per stage) and the 8-stage
// successive-approximation search of the sRGB threshold table. Stalls on the
// output back up stage by stage; empty stages still take new words.
// Registers (APB, byte address 4*i): 0 frame_width, 1 frame_height,
// 2 linear_output. Write them only while the pipeline is empty.
module accum_resolve_srgb_pack_top
  import arsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data
);

  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic        linear_output;
  reg_idx_t    rsel;

  pipe_t       st  [N_STAGES];
  pipe_t       nxt [N_STAGES];
  logic [N_STAGES-1:0] vld;
  logic [N_STAGES-1:0] en;

  assign pready = 1'b1;
  assign rsel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 13'd640;
      frame_height  <= 13'd480;
      linear_output <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (rsel)
        REG_FRAME_WIDTH:   frame_width   <= pwdata[12:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[12:0];
        REG_LINEAR_OUTPUT: linear_output <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (rsel)
      REG_FRAME_WIDTH:   prdata = {19'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {19'd0, frame_height};
      REG_LINEAR_OUTPUT: prdata = {31'd0, linear_output};
      default:           prdata = '0;
    endcase
  end

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[N_STAGES-1] = !vld[N_STAGES-1] || out_ready;
    for (int i = N_STAGES - 2; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end

  always_comb begin
    nxt[0] = pipe_load(in_data, frame_height);
    for (int i = 1; i < N_STAGES; i++)
      nxt[i] = pipe_step(i, st[i-1], linear_output, frame_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < N_STAGES; i++)
        if (en[i]) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_STAGES; i++)
      if (en[i]) st[i] <= nxt[i];
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N_STAGES-1];
  assign out_data.packed_pixel = st[N_STAGES-1].pix;
  assign out_data.dest_index   = st[N_STAGES-1].idx;

endmodule

`default_nettype wire

@@ rtl/arsp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module arsp_checker
  import arsp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.packed_pixel[31:24] == 8'hFF)
    else $error("alpha byte not opaque");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no output pending");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word present right after reset");

endmodule

bind accum_resolve_srgb_pack_top arsp_checker u_arsp_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire

@@ verif/accum_resolve_srgb_pack_top_tb.sv @@
`timescale 1ns / 1ps

module accum_resolve_srgb_pack_top_tb;
  import arsp_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_word_t   out_data;

  accum_resolve_srgb_pack_top uut (.*);

  always #5 clk = ~clk;

  logic [12:0] cfg_width = 13'd640;
  logic [12:0] cfg_height = 13'd480;
  logic        cfg_linear = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;

  in_word_t  pixel_q [$];
  out_word_t expect_q [$];

  // exact sRGB step test: q^5 * 10761^12 >= (40k+541)^12 * 2^80
  function automatic bit srgb_reaches(logic [16:0] q, int unsigned k);
    logic [255:0] lhs;
    logic [255:0] rhs;
    lhs = 256'd1;
    rhs = 256'd1;
    for (int i = 0; i < 5; i++) lhs = lhs * 256'(q);
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * 256'd10761;
      rhs = rhs * 256'(40 * k + 541);
    end
    rhs = rhs << 80;
    return lhs >= rhs;
  endfunction

  function automatic logic [7:0] encode_chan(logic [31:0] sum, logic [31:0] weight);
    logic [16:0] q;
    logic [47:0] num;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = 255;
    if (sum >= weight) q = 17'h10000;
    else begin
      num = {sum, 16'd0};
      q = 17'(num / {16'd0, weight});
    end
    if (cfg_linear) return 8'((32'(q) * 255 + 32768) >> 16);
    if (q <= 17'd205) return 8'((64'(q) * 32946 + 327680) / 655360);
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (srgb_reaches(q, mid)) lo = mid;
      else hi = mid - 1;
    end
    return 8'(lo);
  endfunction

  function automatic out_word_t resolve_pixel(in_word_t w);
    out_word_t r;
    logic [23:0] row;
    r.packed_pixel = 32'hFF000000;
    if (w.accum_weight != 0) begin
      r.packed_pixel[7:0]   = encode_chan(w.accum_red, w.accum_weight);
      r.packed_pixel[15:8]  = encode_chan(w.accum_green, w.accum_weight);
      r.packed_pixel[23:16] = encode_chan(w.accum_blue, w.accum_weight);
    end
    row = 24'(cfg_height) - 24'd1 - 24'(w.pixel_y);
    r.dest_index = 24'(w.pixel_x) + 24'(row * 24'(cfg_width));
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic     nxt_valid;
    in_word_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (rst) begin
      nxt_valid = 0;
    end else begin
      if (in_valid && in_ready) begin
        expect_q.push_back(resolve_pixel(in_data));
        nxt_valid = 0;
      end
      if (!nxt_valid && pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt_data = pixel_q.pop_front();
        nxt_valid = 1;
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // monitor
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, out_data);
        end else begin
          exp_w = expect_q.pop_front();
          if (out_data.packed_pixel !== exp_w.packed_pixel) begin
            errors++;
            $display("%0t: packed_pixel expected %h actual %h", $time,
                     exp_w.packed_pixel, out_data.packed_pixel);
          end
          if (out_data.dest_index !== exp_w.dest_index) begin
            errors++;
            $display("%0t: dest_index expected %h actual %h", $time,
                     exp_w.dest_index, out_data.dest_index);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 4'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = value[12:0];
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = value[12:0];
      end
      REG_LINEAR_OUTPUT: begin
        cfg_linear = value[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_frame(logic [31:0] w, logic [31:0] h, logic [31:0] lin);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_LINEAR_OUTPUT, lin);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0 || expect_q.size() != 0 || in_valid) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic void push_px(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                                  logic [31:0] w, logic [11:0] x, logic [11:0] y);
    in_word_t p;
    p.accum_red = r;
    p.accum_green = g;
    p.accum_blue = b;
    p.accum_weight = w;
    p.pixel_x = x;
    p.pixel_y = y;
    pixel_q.push_back(p);
  endfunction

  // mostly sums below the weight so the curve is exercised, some saturating
  function automatic logic [31:0] rand_sum(logic [31:0] w);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'(64'(w) * $urandom_range(0, 300) >> 16);
      2: return w;
      default: return (w == 0) ? 32'($urandom()) : 32'(64'(w) * $urandom() >> 32);
    endcase
  endfunction

  task automatic push_random(int n);
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: w = $urandom();
        1: w = $urandom_range(1, 65535);
        2: w = 32'(1) << $urandom_range(0, 31);
        default: w = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 32'h00FFFFFF);
      endcase
      push_px(rand_sum(w), rand_sum(w), rand_sum(w), w,
              12'($urandom()), 12'($urandom()));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, defaults rewritten
    set_frame(640, 480, 0);
    push_px(0, 0, 0, 0, 0, 0);
    push_px(32'hFFFFFFFF, 1, 0, 0, 12'hFFF, 12'hFFF);
    push_px(0, 0, 0, 32'hFFFFFFFF, 0, 479);
    push_px(32'hFFFFFFFF, 32'hFFFFFFFE, 32'h7FFFFFFF, 32'hFFFFFFFF, 639, 0);
    push_px(205, 206, 204, 65536, 1, 1);
    push_px(203, 207, 1, 65536, 2, 2);
    push_px(5, 10, 4096, 4096, 100, 500);
    push_px(1, 2, 3, 1, 12'hFFF, 0);
    push_px(32'h80000000, 32'h40000000, 32'h00001000, 32'hFFFFFFFF, 0, 12'hFFF);
    push_px(32768, 16384, 65535, 65536, 7, 8);
    push_px(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 3, 3);
    push_px(1, 1, 1, 32'hFFFFFFFF, 12'h555, 12'hAAA);
    drain();
    reg_write(REG_LINEAR_OUTPUT, 1);
    push_px(32768, 16384, 65535, 65536, 7, 8);
    push_px(205, 206, 1, 65536, 0, 0);
    push_px(32'hFFFFFFFF, 0, 1, 2, 12'hFFF, 12'hFFF);
    push_px(0, 0, 0, 0, 1, 2);
    drain();

    // no idling
    idle_pct = 0;
    stall_pct = 0;
    set_frame(1, 1, 0);
    push_random(150);
    drain();

    // sender gaps, with a full pause in the middle
    idle_pct = 47;
    stall_pct = 0;
    set_frame(4096, 4096, 1);
    push_random(70);
    drain();
    push_random(70);
    drain();

    // receiver stalls
    idle_pct = 0;
    stall_pct = 47;
    set_frame(0, 8191, 0);
    push_random(150);
    drain();

    // both
    idle_pct = 21;
    stall_pct = 21;
    set_frame(8191, 0, 1);
    push_random(75);
    drain();
    set_frame(1920, 1080, 0);
    push_random(75);
    drain();

    if (errors == 0) $display("accum_resolve_srgb_pack_top test passed");
    else $display("accum_resolve_srgb_pack_top test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("accum_resolve_srgb_pack_top test failed");
    $finish;
  end

endmodule

@@ accum_resolve_srgb_pack_top.f @@
rtl/arsp_pkg.sv
rtl/accum_resolve_srgb_pack_top.sv
rtl/arsp_checker.sv
verif/accum_resolve_srgb_pack_top_tb.sv
